FILE: sv/tdpt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tdpt_pkg
// Shared types and constants for the trial division prime test unit.
// ============================================================================
package tdpt_pkg;

   localparam int NUMBER_WIDTH  = 32;
   localparam int DEFAULT_WIDTH = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV3,
      ST_BOUND,
      ST_DIV_I,
      ST_DIV_I2,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic done;
      logic rem_zero;
   } div_stat_type;

endpackage

FILE: sv/tdpt_div.sv
`timescale 1ns / 1ps
// ============================================================================
// tdpt_div
// Radix-2 restoring remainder unit, one dividend bit per cycle.
// ============================================================================
module tdpt_div #(
   parameter int WIDTH = tdpt_pkg::DEFAULT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tdpt_pkg::div_ctrl_type ctrl,
   input  logic [WIDTH-1:0]       dividend,
   input  logic [WIDTH-1:0]       divisor,
   output tdpt_pkg::div_stat_type stat
);
   import tdpt_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvd_ff, dvd_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   partial;
   logic [WIDTH:0]   diff;
   logic             fits;

   always_comb begin
      partial = {rem_ff, dvd_ff[WIDTH-1]};
      diff    = partial - {1'b0, dsr_ff};
      fits    = partial >= {1'b0, dsr_ff};
   end

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[WIDTH-1:0] : partial[WIDTH-1:0];
         dvd_in = {dvd_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.done     = done_ff;
   assign stat.rem_zero = (rem_ff == '0);

endmodule

FILE: sv/trial_division_prime_test_unit.sv
`timescale 1ns / 1ps
// Negatives, 0..3 and even values go from ST_CHECK straight to ST_RESULT.
// Otherwise the number is tested by 3, then by each divisor pair i, i+2, on
// the shared remainder unit (one dividend bit per cycle).
// Throughput: one item at a time; req_ready returns once the result is loaded.
// Reset: synchronous, active high; clears the sequencer and rsp_valid.
// ============================================================================
// trial_division_prime_test_unit
// Primality test by trial division over 6k-1 / 6k+1 divisors.
// ============================================================================
module trial_division_prime_test_unit #(
   parameter int WIDTH = tdpt_pkg::DEFAULT_WIDTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [tdpt_pkg::NUMBER_WIDTH-1:0] req_number,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_is_prime
);
   import tdpt_pkg::*;

   localparam int IW = (WIDTH + 1) / 2 + 1;
   localparam int SW = WIDTH + 1;

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] n_ff, n_in;
   logic [IW-1:0]    i_ff, i_in;
   logic [SW-1:0]    sq_ff, sq_in;
   logic             verdict_ff, verdict_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_is_prime_ff, rsp_is_prime_in;

   logic [WIDTH-1:0] num_ext;
   logic [WIDTH-1:0] dsr;
   div_ctrl_type     div_ctrl;
   div_stat_type     div_stat;

   logic             n_neg;
   logic             n_le1;
   logic             n_le3;
   logic             fast_done;
   logic             fast_verdict;
   logic             past_bound;
   logic             out_free;
   logic [IW-1:0]    i_plus2;

   generate
      if (WIDTH <= NUMBER_WIDTH) begin : g_narrow
         assign num_ext = req_number[WIDTH-1:0];
      end else begin : g_wide
         assign num_ext = {{(WIDTH - NUMBER_WIDTH){1'b0}}, req_number};
      end
   endgenerate

   always_comb begin
      n_neg        = n_ff[WIDTH-1];
      n_le1        = n_ff <= WIDTH'(1);
      n_le3        = n_ff <= WIDTH'(3);
      fast_done    = n_neg || n_le3 || !n_ff[0];
      fast_verdict = !n_neg && n_le3 && !n_le1;
      past_bound   = sq_ff > {1'b0, n_ff};
      out_free     = !rsp_valid_ff || rsp_ready;
      i_plus2      = i_ff + IW'(2);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = fast_done ? ST_RESULT : ST_DIV3;
         end
         ST_DIV3: begin
            if (div_stat.done) state_in = div_stat.rem_zero ? ST_RESULT : ST_BOUND;
         end
         ST_BOUND: begin
            state_in = past_bound ? ST_RESULT : ST_DIV_I;
         end
         ST_DIV_I: begin
            if (div_stat.done) state_in = div_stat.rem_zero ? ST_RESULT : ST_DIV_I2;
         end
         ST_DIV_I2: begin
            if (div_stat.done) state_in = div_stat.rem_zero ? ST_RESULT : ST_BOUND;
         end
         ST_RESULT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready       = 1'b0;
      div_ctrl.start  = 1'b0;
      dsr             = WIDTH'(3);
      n_in            = n_ff;
      i_in            = i_ff;
      sq_in           = sq_ff;
      verdict_in      = verdict_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_is_prime_in = rsp_is_prime_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) n_in = num_ext;
         end
         ST_CHECK: begin
            i_in       = IW'(5);
            sq_in      = SW'(25);
            verdict_in = fast_verdict;
            dsr        = WIDTH'(3);
            if (!fast_done) div_ctrl.start = 1'b1;
         end
         ST_DIV3: begin
            verdict_in = 1'b0;
         end
         ST_BOUND: begin
            verdict_in = 1'b1;
            dsr        = WIDTH'(i_ff);
            if (!past_bound) div_ctrl.start = 1'b1;
         end
         ST_DIV_I: begin
            verdict_in = 1'b0;
            dsr        = WIDTH'(i_plus2);
            if (div_stat.done && !div_stat.rem_zero) div_ctrl.start = 1'b1;
         end
         ST_DIV_I2: begin
            verdict_in = 1'b0;
            if (div_stat.done && !div_stat.rem_zero) begin
               i_in  = i_ff + IW'(6);
               sq_in = sq_ff + (SW'(i_ff) << 3) + (SW'(i_ff) << 2) + SW'(36);
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_is_prime_in = verdict_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n_ff            <= n_in;
      i_ff            <= i_in;
      sq_ff           <= sq_in;
      verdict_ff      <= verdict_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   tdpt_div #(
      .WIDTH (WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (n_ff),
      .divisor  (dsr),
      .stat     (div_stat)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

endmodule

FILE: sv/tdpt_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// tdpt_checker
// Port-level checks for the trial division prime test unit.
// ============================================================================
module tdpt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_is_prime
);

   // stalled result transfer keeps valid and payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_prime))
      else $error("rsp dropped or changed while stalled");

   // one item in flight: busy right after an input transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an input transfer");

   // a result cannot appear the cycle after an input transfer
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("rsp_valid rose too early after an input transfer");

   // a new result is loaded only together with the return to ready
   a_rsp_with_ready: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result loaded while still busy");

endmodule

bind trial_division_prime_test_unit tdpt_checker u_tdpt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_is_prime (rsp_is_prime)
);

FILE: dv/trial_division_prime_test_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// trial_division_prime_test_checker
// Watches the request and response channels of the prime test unit, predicts
// the verdict for every accepted number and compares it with the response.
// ============================================================================
module trial_division_prime_test_checker #(
   parameter int WIDTH = tdpt_pkg::DEFAULT_WIDTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_ready,
   input  logic signed [tdpt_pkg::NUMBER_WIDTH-1:0] req_number,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   input  logic                                     rsp_is_prime,
   output int                                       fail_count,
   output int                                       outstanding
);

   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic signed [tdpt_pkg::NUMBER_WIDTH-1:0] number;
      bit                                       verdict;
   } verdict_entry_type;

   verdict_entry_type expected_verdicts[$];

   // number is read as a WIDTH-bit two's complement value
   function automatic bit trial_divide_prime(input logic [tdpt_pkg::NUMBER_WIDTH-1:0] word);
      longint unsigned mask;
      longint unsigned sign_bit;
      longint unsigned n;
      longint unsigned d;
      mask     = (WIDTH >= 64) ? '1 : ((64'd1 << WIDTH) - 64'd1);
      sign_bit = 64'd1 << (WIDTH - 1);
      n        = word;
      n        = n & mask;
      if ((n & sign_bit) != 0) return 1'b0;
      if (n <= 1) return 1'b0;
      if (n <= 3) return 1'b1;
      if ((n % 2) == 0 || (n % 3) == 0) return 1'b0;
      for (d = 5; d <= n / d; d += 6) begin
         if ((n % d) == 0 || (n % (d + 2)) == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      verdict_entry_type head;
      verdict_entry_type entry;
      if (reset) begin
         fail_count  <= 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("[%0t] unexpected response is_prime=%b, none pending",
                           $realtime, rsp_is_prime);
               fail_count <= fail_count + 1;
            end else begin
               head = expected_verdicts.pop_front();
               if (rsp_is_prime !== head.verdict) begin
                  if (fail_count < REPORT_LIMIT)
                     $display("[%0t] mismatch number=%0d is_prime expected %b actual %b",
                              $realtime, head.number, head.verdict, rsp_is_prime);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            entry.number  = req_number;
            entry.verdict = trial_divide_prime(req_number);
            expected_verdicts.push_back(entry);
         end
         outstanding <= expected_verdicts.size();
      end
   end

endmodule

FILE: dv/trial_division_prime_test_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// trial_division_prime_test_unit_tb
// Drives directed and random numbers into the prime test unit under varying
// sender and receiver backpressure; the checker predicts and compares.
// ============================================================================
module trial_division_prime_test_unit_tb;
   import tdpt_pkg::*;

   localparam int RANDOM_ITEMS = 76;
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int DRAIN_CYCLES = 20;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic signed [NUMBER_WIDTH-1:0] req_number = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_is_prime;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count   = 0;
   int fail_count;
   int outstanding;

   logic signed [NUMBER_WIDTH-1:0] test_numbers[$];

   trial_division_prime_test_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_number   (req_number),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_prime (rsp_is_prime)
   );

   trial_division_prime_test_checker checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_number   (req_number),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_prime (rsp_is_prime),
      .fail_count   (fail_count),
      .outstanding  (outstanding)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** trial_division_prime_test_unit: FAILED **");
         $finish;
      end
   end

   // Mostly cheap values: large positives get a small factor so the divisor
   // loop ends early; the slow cases stay small.
   function automatic logic signed [NUMBER_WIDTH-1:0] pick_number();
      int unsigned kind;
      int unsigned a;
      int unsigned b;
      int unsigned m;
      logic [31:0] v;
      kind = $urandom_range(99);
      if (kind < 10) begin
         v = {1'b1, 31'($urandom)};
      end else if (kind < 40) begin
         v = $urandom_range(4095);
      end else if (kind < 55) begin
         a = 6 * $urandom_range(1, 33) - 1 + 2 * $urandom_range(1);
         b = ($urandom_range(3) == 0) ? a
                                      : 6 * $urandom_range(1, 33) - 1 + 2 * $urandom_range(1);
         v = a * b;
      end else if (kind < 65) begin
         v = $urandom_range(262143);
      end else if (kind < 85) begin
         v = $urandom & 32'h7FFF_FFFF;
         m = $urandom_range(2, 13);
         v = v - (v % m);
      end else begin
         v = 6 * $urandom_range(1, 10922) - 1 + 2 * $urandom_range(1);
      end
      return v;
   endfunction

   task automatic send_number(input logic signed [NUMBER_WIDTH-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid  <= 1'b1;
      req_number <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      int total;
      test_numbers = '{0, 1, 2, 3, 4, 5, 7, 9, -1, 32'sh8000_0000, 32'sh7FFF_FFFF,
                       32'sh7FFF_FFFE, 32'sh7FFF_FFFD, 25, 49, 121, 169, 289, 35, 143,
                       29, 97, 65521, 1000003};
      repeat (RANDOM_ITEMS) test_numbers.push_back(pick_number());
      total = test_numbers.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (test_numbers[k]) begin
         if (k < total / 3) begin
            send_idle_pct = 16;
            recv_idle_pct <= 70;
         end else if (k < 2 * total / 3) begin
            send_idle_pct = 70;
            recv_idle_pct <= 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
         send_number(test_numbers[k]);
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("** trial_division_prime_test_unit: PASSED **");
      end else begin
         $display("** trial_division_prime_test_unit: FAILED **");
      end
      $finish;
   end

endmodule
